FILE: hw/rtl/dct_pkg.sv
// ----------------------------------------------------------------------------
// dct_pkg
// shared constants for the digest count table
// ----------------------------------------------------------------------------
`default_nettype none
package dct_pkg;
  localparam int unsigned DefBuckets = 1024;
  localparam int unsigned DefWays    = 4;
  localparam logic [31:0] FnvBasis   = 32'd2166136261;
  localparam logic [31:0] FnvPrime   = 32'd16777619;
  localparam logic [15:0] CountMax   = 16'hFFFF;
  localparam int unsigned KeyW       = 256;
  localparam int unsigned SizeW      = 48;
  localparam int unsigned CountW     = 16;
  localparam int unsigned SlotW      = 12;
  localparam int unsigned InW        = 304;
  localparam int unsigned OutW       = 80;
endpackage
`default_nettype wire

FILE: hw/rtl/dct_ram.sv
// ----------------------------------------------------------------------------
// dct_ram
// single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module dct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

FILE: hw/rtl/digest_count_table.sv
// ----------------------------------------------------------------------------
// digest_count_table
// fnv-1a hashed digest table with per-entry saturating occurrence counts
// ----------------------------------------------------------------------------
// channel  dir  tdata (low bit first)
// s_axis   in   digest_word0..3, file_size (304 bits)
// m_axis   out  slot, occurrences, stored_size, is_new, is_duplicate,
//               bucket_full (80 bits)
//
// an item passes an accept state, the byte-serial hash over its digest,
// the bucket reduction (reciprocal multiply, remainder, a correction while
// the remainder is still at least BUCKETS), a read and an evaluate state
// for each way in turn over the single ram port, then a write and an output
// state. after reset the table is swept, one slot per cycle, with
// s_axis_tready low. a result held in the output register does not block
// the next item's hashing; the next item waits in its output state.
`default_nettype none
module digest_count_table import dct_pkg::*; #(
  parameter int unsigned BUCKETS = DefBuckets,
  parameter int unsigned WAYS    = DefWays
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // digest_word0, digest_word1, digest_word2, digest_word3, file_size
  input  wire logic [InW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // slot, occurrences, stored_size, is_new, is_duplicate, bucket_full
  output logic [OutW-1:0]      m_axis_tdata
);
  localparam int unsigned Slots = BUCKETS * WAYS;
  localparam int unsigned AW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned EW    = 1 + KeyW + SizeW + CountW;
  localparam logic [31:0] BucketsW = 32'(BUCKETS);
  localparam logic [31:0] RecipM   = 32'(32'hFFFF_FFFF / BUCKETS);

  typedef enum logic [3:0] {
    StClear, StIdle, StHash, StMod, StRem, StFix, StRead, StEval, StWrite, StOut
  } state_e;

  state_e             state_q;
  logic [AW-1:0]      clr_q;
  logic [KeyW-1:0]    key_q;
  logic [SizeW-1:0]   size_q;
  logic [31:0]        h_q;
  logic [4:0]         byte_q;
  logic [31:0]        q_q;
  logic [31:0]        rem_q;
  logic [BW-1:0]      bucket_q;
  logic [WW:0]        way_q;
  logic               hit_q, free_q;
  logic [WW-1:0]      hit_way_q, free_way_q;
  logic [CountW-1:0]  hit_cnt_q;
  logic [SizeW-1:0]   hit_size_q;
  logic [OutW-1:0]    res_q;
  logic               ovalid_q;

  logic               we;
  logic [AW-1:0]      addr;
  logic [EW-1:0]      wdata, rdata;
  logic [AW-1:0]      base;
  logic [7:0]         cur_byte;
  logic [31:0]        h_x;
  logic [31:0]        h_mul;
  logic [63:0]        q_mul;
  logic               rvalid;
  logic [KeyW-1:0]    rkey;
  logic [SizeW-1:0]   rsize;
  logic [CountW-1:0]  rcnt;
  logic [CountW-1:0]  new_cnt;
  logic [AW-1:0]      wslot;
  logic [SlotW-1:0]   oslot;
  logic [AW+SlotW-1:0] wslot_x;
  logic [OutW-1:0]    res_d;
  logic               out_load;

  assign base     = AW'(bucket_q) * AW'(WAYS);
  // byte n of the digest sits in word n/8, bits 63-8*(n%8) down
  assign cur_byte = key_q[{byte_q[4:3], ~byte_q[2:0], 3'b000} +: 8];
  assign h_x      = h_q ^ {24'd0, cur_byte};
  assign h_mul    = h_x * FnvPrime;
  assign q_mul    = 64'(h_q) * 64'(RecipM);
  assign {rvalid, rkey, rsize, rcnt} = rdata;
  assign new_cnt  = (hit_cnt_q == CountMax) ? hit_cnt_q : hit_cnt_q + 1'b1;
  assign wslot    = base + AW'(hit_q ? hit_way_q : free_way_q);
  assign wslot_x  = {{SlotW{1'b0}}, wslot};
  assign oslot    = wslot_x[SlotW-1:0];
  assign out_load = (state_q == StOut) && (!ovalid_q || m_axis_tready);

  always_comb begin
    if (hit_q) begin
      res_d = {1'b0, 1'b0, (new_cnt >= 16'd2), 1'b0, hit_size_q, new_cnt, oslot};
    end else if (free_q) begin
      res_d = {1'b0, 1'b0, 1'b0, 1'b1, size_q, 16'd1, oslot};
    end else begin
      res_d = {1'b0, 1'b1, {(OutW-2){1'b0}}};
    end
  end

  always_comb begin
    we    = 1'b0;
    addr  = base + AW'(way_q[WW-1:0]);
    wdata = '0;
    if (state_q == StClear) begin
      we   = 1'b1;
      addr = clr_q;
    end else if (state_q == StWrite && (hit_q || free_q)) begin
      we    = 1'b1;
      addr  = wslot;
      wdata = hit_q ? {1'b1, key_q, hit_size_q, new_cnt}
                    : {1'b1, key_q, size_q, 16'd1};
    end
  end

  dct_ram #(.Width(EW), .Depth(Slots)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_q      <= '0;
      ovalid_q   <= 1'b0;
      way_q      <= '0;
      byte_q     <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
    end else begin
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(Slots - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (s_axis_tvalid) begin
            key_q   <= s_axis_tdata[KeyW-1:0];
            size_q  <= s_axis_tdata[KeyW +: SizeW];
            h_q     <= FnvBasis;
            byte_q  <= '0;
            state_q <= StHash;
          end
        end
        StHash: begin
          h_q    <= h_mul;
          byte_q <= byte_q + 1'b1;
          if (byte_q == 5'd31) begin
            state_q <= StMod;
          end
        end
        StMod: begin
          q_q     <= q_mul[63:32];
          state_q <= StRem;
        end
        StRem: begin
          rem_q   <= h_q - q_q * BucketsW;
          state_q <= StFix;
        end
        StFix: begin
          if (rem_q >= BucketsW) begin
            rem_q <= rem_q - BucketsW;
          end else begin
            bucket_q <= BW'(rem_q);
            way_q    <= '0;
            hit_q    <= 1'b0;
            free_q   <= 1'b0;
            state_q  <= StRead;
          end
        end
        StRead: begin
          state_q <= StEval;
        end
        StEval: begin
          if (rvalid) begin
            if (!hit_q && rkey == key_q) begin
              hit_q      <= 1'b1;
              hit_way_q  <= way_q[WW-1:0];
              hit_cnt_q  <= rcnt;
              hit_size_q <= rsize;
            end
          end else if (!free_q) begin
            free_q     <= 1'b1;
            free_way_q <= way_q[WW-1:0];
          end
          if (way_q == (WW+1)'(WAYS - 1)) begin
            state_q <= StWrite;
          end else begin
            way_q   <= way_q + 1'b1;
            state_q <= StRead;
          end
        end
        StWrite: begin
          state_q <= StOut;
        end
        StOut: begin
          if (out_load) begin
            res_q   <= res_d;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: bench/dct_checker.sv
// ----------------------------------------------------------------------------
// dct_checker
// watches both streams of the digest count table, keeps a shadow table of
// buckets and ways, predicts each result word and compares it field by field
// ----------------------------------------------------------------------------
`default_nettype none
module dct_checker import dct_pkg::*; #(
  parameter int unsigned BUCKETS = DefBuckets,
  parameter int unsigned WAYS    = DefWays
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  input  wire logic            s_axis_tready,
  input  wire logic [InW-1:0]  s_axis_tdata,
  input  wire logic            m_axis_tvalid,
  input  wire logic            m_axis_tready,
  input  wire logic [OutW-1:0] m_axis_tdata,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   new_count_o,
  output int                   dup_count_o,
  output int                   full_count_o
);
  localparam int unsigned Slots = BUCKETS * WAYS;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] occurrences;
    logic [SizeW-1:0]  stored_size;
    logic              is_new;
    logic              is_duplicate;
    logic              bucket_full;
  } result_t;

  logic              shadow_valid [Slots];
  logic [KeyW-1:0]   shadow_key   [Slots];
  logic [SizeW-1:0]  shadow_size  [Slots];
  logic [CountW-1:0] shadow_count [Slots];
  result_t           expected_results [$];

  // fnv-1a over digest bytes 0..31, byte 0 in the top of word 0
  function automatic int unsigned hash_bucket(input logic [KeyW-1:0] digest);
    logic [31:0] h;
    h = FnvBasis;
    for (int w = 0; w < 4; w++) begin
      for (int b = 0; b < 8; b++) begin
        h = h ^ {24'd0, digest[64*w + 56 - 8*b +: 8]};
        h = h * FnvPrime;
      end
    end
    return h % BUCKETS;
  endfunction

  function automatic result_t count_digest(input logic [KeyW-1:0] digest,
                                           input logic [SizeW-1:0] fsize);
    int unsigned base;
    int          hit;
    int          free_way;
    int unsigned s;
    result_t     r;
    base = hash_bucket(digest) * WAYS;
    hit = -1;
    free_way = -1;
    r = '0;
    for (int w = 0; w < WAYS; w++) begin
      s = base + w;
      if (shadow_valid[s]) begin
        if (hit < 0 && shadow_key[s] == digest) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (hit >= 0) begin
      s = base + hit;
      if (shadow_count[s] != CountMax) shadow_count[s] = shadow_count[s] + 1'b1;
      r.slot = s[SlotW-1:0];
      r.occurrences = shadow_count[s];
      r.stored_size = shadow_size[s];
      r.is_duplicate = shadow_count[s] >= 2;
    end else if (free_way >= 0) begin
      s = base + free_way;
      shadow_valid[s] = 1'b1;
      shadow_key[s] = digest;
      shadow_size[s] = fsize;
      shadow_count[s] = 1;
      r.slot = s[SlotW-1:0];
      r.occurrences = 1;
      r.stored_size = fsize;
      r.is_new = 1'b1;
    end else begin
      r.bucket_full = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) shadow_valid[i] = 1'b0;
      expected_results.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      new_count_o <= 0;
      dup_count_o <= 0;
      full_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.slot         = m_axis_tdata[11:0];
        got.occurrences  = m_axis_tdata[27:12];
        got.stored_size  = m_axis_tdata[75:28];
        got.is_new       = m_axis_tdata[76];
        got.is_duplicate = m_axis_tdata[77];
        got.bucket_full  = m_axis_tdata[78];
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected: %h", $time, m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            $display("%0t: mismatch slot exp %0d act %0d, occurrences exp %0d act %0d",
                     $time, want.slot, got.slot, want.occurrences, got.occurrences);
            $display("%0t:   stored_size exp %0d act %0d, new/dup/full exp %b%b%b act %b%b%b",
                     $time, want.stored_size, got.stored_size, want.is_new,
                     want.is_duplicate, want.bucket_full, got.is_new,
                     got.is_duplicate, got.bucket_full);
            fail_count_o <= fail_count_o + 1;
          end
          if (want.is_new) new_count_o <= new_count_o + 1;
          if (want.is_duplicate) dup_count_o <= dup_count_o + 1;
          if (want.bucket_full) full_count_o <= full_count_o + 1;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(count_digest(s_axis_tdata[KeyW-1:0],
                                                s_axis_tdata[InW-1:KeyW]));
      pending_o <= expected_results.size();
    end
  end
endmodule
`default_nettype wire

FILE: bench/tb_digest_count_table.sv
// ----------------------------------------------------------------------------
// tb_digest_count_table
// drives digests into the count table: directed edge values, a forced bucket
// overflow, then random fresh, repeated and colliding digests under four
// idle and stall mixes; the checker beside the block judges every result
// ----------------------------------------------------------------------------
`default_nettype none
module tb_digest_count_table;
  import dct_pkg::*;

  localparam int RandomWords = 650;
  localparam int QuietLimit  = 20000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  // digest_word0, digest_word1, digest_word2, digest_word3, file_size
  logic [InW-1:0]  s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  // slot, occurrences, stored_size, is_new, is_duplicate, bucket_full
  logic [OutW-1:0] m_axis_tdata;

  int fail_count, pending, new_count, dup_count, full_count;
  int idle_mode;
  int sent;
  int quiet_cycles;
  logic [KeyW-1:0] digest_pool [$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  digest_count_table u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  dct_checker u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending),
    .new_count_o(new_count), .dup_count_o(dup_count), .full_count_o(full_count)
  );

  // receiver stalls 84 in a hundred in mode 2, 16 in mode 3
  always @(posedge clk_i) begin
    if (idle_mode == 2) begin
      m_axis_tready <= ($urandom_range(99) >= 84);
    end else if (idle_mode == 3) begin
      m_axis_tready <= ($urandom_range(99) >= 16);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [KeyW-1:0] random_digest();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [SizeW-1:0] random_size();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return {16'($urandom_range(65535)), $urandom};
      default: return SizeW'($urandom_range(1 << 20));
    endcase
  endfunction

  function automatic logic [KeyW-1:0] digest_in_bucket(input int unsigned bucket);
    logic [KeyW-1:0] d;
    do d = random_digest(); while (u_chk.hash_bucket(d) != bucket);
    return d;
  endfunction

  task automatic send_word(input logic [KeyW-1:0] digest, input logic [SizeW-1:0] fsize);
    int unsigned idle_pct;
    idle_pct = (idle_mode == 1) ? 84 : (idle_mode == 3) ? 16 : 0;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {fsize, digest};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
    digest_pool.push_back(digest);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  initial begin
    logic [KeyW-1:0] crowd [5];
    logic [KeyW-1:0] d;
    int unsigned pick;
    idle_mode = 0;
    sent = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge values and repeats
    send_word('0, '0);
    send_word('1, '1);
    send_word('0, 48'd12345);
    send_word('0, 48'd1);
    send_word({4{64'hAAAA_AAAA_AAAA_AAAA}}, 48'h5555_5555_5555);
    send_word({4{64'h5555_5555_5555_5555}}, 48'hAAAA_AAAA_AAAA);
    send_word('1, '0);
    // overflow one bucket: four new ways, then a fifth digest is refused
    pick = $urandom_range(DefBuckets - 1);
    for (int i = 0; i < 5; i++) begin
      crowd[i] = digest_in_bucket(pick);
      send_word(crowd[i], random_size());
    end
    send_word(crowd[3], '1);
    send_word(crowd[4], '0);
    send_word(crowd[0], 48'd7);

    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = ph;
      for (int n = 0; n < RandomWords / 4; n++) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
            d = digest_pool[$urandom_range(digest_pool.size() - 1)];
          10, 11, 12:
            d = digest_in_bucket(
                u_chk.hash_bucket(digest_pool[$urandom_range(digest_pool.size() - 1)]));
          default:
            d = random_digest();
        endcase
        send_word(d, random_size());
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("sent %0d digest words over four idle/stall mixes", sent);
    $display("new entries %0d, duplicates %0d, full buckets %0d",
             new_count, dup_count, full_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
